// ----- design/sahbss_pkg.sv -----
`default_nettype none
package sahbss_pkg;

    localparam int MAX_BOXES_DEF  = 256;
    localparam int BUCKETS_DEF    = 12;
    localparam int COORD_BITS_DEF = 16;

    localparam int CFG_W = 9;
    localparam logic [CFG_W-1:0] LEAF_RESET = 9'd255;

    localparam int OUTCOME_W = 2;
    localparam int AXIS_W    = 2;
    localparam int BUCKET_W  = 4;
    localparam int CNT_W     = 9;
    localparam int SUM_OUT_W = 42;
    localparam int M_FIELDS_W = OUTCOME_W + AXIS_W + BUCKET_W + 2 * CNT_W + SUM_OUT_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [OUTCOME_W-1:0] {
        OUT_SINGLE    = 2'd0,
        OUT_DEGEN     = 2'd1,
        OUT_COST_LEAF = 2'd2,
        OUT_SPLIT     = 2'd3
    } outcome_t;

    typedef enum logic [AXIS_W-1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } axis_t;

endpackage
`default_nettype wire

// ----- design/sahbss_ram.sv -----
`default_nettype none
module sahbss_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 256,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// ----- design/sah_binned_split_select.sv -----
// Binned surface-area-heuristic split selection for one node.
// Input channel (s_): one primitive box per transaction, s_tlast marks the
// last box of the node. Boxes are taken one per cycle while the block is
// loading; they are kept in a box memory and the node and centroid bounds
// grow as they arrive. Boxes beyond MAX_BOXES are dropped, but their
// s_tlast still closes the node.
// After the last box the block stops taking boxes until its decision is
// in the output register: one memory read per box to bin the centroids,
// then a left and a right sweep over the buckets through a three-stage
// area pipeline, a search over the cuts for the cheapest one, and the cost
// test. The box memory's single read port sets the binning time.
// Output channel (m_): one decision per node, held in an output register.
// While it waits for m_tready the block already loads the next node; it
// only holds before delivering the following decision.
// cfg_wen writes max_leaf_size; the user must write it only while the block is idle, the block does not enforce this.
// Reset (aresetn low, synchronous) empties the node, drops any pending
// decision and sets max_leaf_size to 255.
`default_nettype none
module sah_binned_split_select
    import sahbss_pkg::*;
#(
    parameter int MAX_BOXES  = MAX_BOXES_DEF,
    parameter int BUCKETS    = BUCKETS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int S_TDATA_W = ((6 * COORD_BITS + 7) / 8) * 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // min_x, min_y, min_z, max_x, max_y, max_z from the lowest bit up
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // outcome, split_axis, split_bucket, left_count, right_count,
    // best_area_sum from the lowest bit up
    output logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 cfg_wen,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    localparam int BOX_W  = 6 * COORD_BITS;
    localparam int ADDR_W = $clog2(MAX_BOXES);
    localparam int N_W    = $clog2(MAX_BOXES + 1);
    localparam int CEN_W  = COORD_BITS + 1;
    localparam int DIF_W  = CEN_W + 1;
    localparam int BK_W   = $clog2(BUCKETS);
    localparam int SC_W   = DIF_W + $clog2(BUCKETS + 1);
    localparam int AREA_W = 2 * COORD_BITS + 2;
    localparam int PROD_W = N_W + AREA_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int COST_W = SUM_W + 3;
    localparam int CUTS   = BUCKETS - 1;
    localparam int CUT_W  = (CUTS > 1) ? $clog2(CUTS) : 1;
    localparam int ST_W   = $clog2(2 * BUCKETS);
    localparam int CMP_W  = (N_W > CFG_W) ? N_W : CFG_W;

    localparam logic [COORD_BITS-1:0] C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic [COORD_BITS-1:0] C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam logic [CEN_W-1:0] CEN_MAX = {1'b0, {(CEN_W-1){1'b1}}};
    localparam logic [CEN_W-1:0] CEN_MIN = {1'b1, {(CEN_W-1){1'b0}}};

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef struct packed {
        coord_t [2:0] hi;
        coord_t [2:0] lo;
    } box_t;

    typedef enum logic [3:0] {
        S_LOAD, S_AXIS, S_THR, S_BIN, S_CUT, S_BEST, S_COST, S_DEC, S_FIN
    } state_t;

    typedef enum logic [1:0] {K_LEFT, K_RIGHT, K_NODE} kind_t;

    function automatic box_t empty_box();
        box_t r;
        for (int k = 0; k < 3; k++) begin
            r.lo[k] = C_MAX;
            r.hi[k] = C_MIN;
        end
        return r;
    endfunction

    function automatic box_t box_grow(box_t a, box_t b);
        box_t r;
        r = a;
        for (int k = 0; k < 3; k++) begin
            if ($signed(b.lo[k]) < $signed(a.lo[k])) r.lo[k] = b.lo[k];
            if ($signed(b.hi[k]) > $signed(a.hi[k])) r.hi[k] = b.hi[k];
        end
        return r;
    endfunction

    function automatic logic [CEN_W-1:0] cen_sum(coord_t lo, coord_t hi);
        return CEN_W'($signed({lo[COORD_BITS-1], lo}) + $signed({hi[COORD_BITS-1], hi}));
    endfunction

    state_t state_reg;

    logic [N_W-1:0]   cnt_reg;
    box_t             nb_reg;
    logic [CEN_W-1:0] cl_reg [3];
    logic [CEN_W-1:0] ch_reg [3];
    logic [CFG_W-1:0] max_leaf_reg;

    logic [AXIS_W-1:0] axis_reg;
    logic [DIF_W-1:0]  dsel_reg;
    logic [CEN_W-1:0]  lowsel_reg;
    logic [SC_W-1:0]   thr_reg [CUTS];

    logic [N_W-1:0]   rd_cnt_reg;
    logic             rv_reg;
    logic             p1_valid_reg;
    logic [DIF_W-1:0] p1_diff_reg;
    box_t             p1_box_reg;
    logic             p2_valid_reg;
    logic [SC_W-1:0]  p2_sc_reg;
    box_t             p2_box_reg;
    logic             p3_valid_reg;
    logic [BK_W-1:0]  p3_bk_reg;
    box_t             p3_box_reg;

    logic [N_W-1:0] bcnt_reg [BUCKETS];
    box_t           bbox_reg [BUCKETS];

    logic [ST_W-1:0] st_reg;
    box_t            acc_reg;
    logic [N_W-1:0]  acnt_reg;

    logic                    a_valid_reg;
    box_t                    a_box_reg;
    logic [N_W-1:0]          a_cnt_reg;
    kind_t                   a_kind_reg;
    logic [CUT_W-1:0]        a_tag_reg;
    logic                    b_valid_reg;
    logic [2*COORD_BITS-1:0] b_p_reg [3];
    logic [N_W-1:0]          b_cnt_reg;
    kind_t                   b_kind_reg;
    logic [CUT_W-1:0]        b_tag_reg;
    logic                    c_valid_reg;
    logic [AREA_W-1:0]       c_area_reg;
    logic [N_W-1:0]          c_cnt_reg;
    kind_t                   c_kind_reg;
    logic [CUT_W-1:0]        c_tag_reg;

    logic [PROD_W-1:0] lsum_reg [CUTS];
    logic [PROD_W-1:0] rsum_reg [CUTS];
    logic [N_W-1:0]    lcnt_reg [CUTS];
    logic [N_W-1:0]    rcnt_reg [CUTS];
    logic [AREA_W-1:0] narea_reg;

    logic [CUT_W-1:0]  bi_reg;
    logic [SUM_W-1:0]  best_reg;
    logic [CUT_W-1:0]  bcut_reg;
    logic [N_W-1:0]    bl_reg;
    logic [N_W-1:0]    br_reg;
    logic [COST_W-1:0] rhs_reg;

    outcome_t             res_outcome_reg;
    logic [AXIS_W-1:0]    res_axis_reg;
    logic [BUCKET_W-1:0]  res_bk_reg;
    logic [CNT_W-1:0]     res_l_reg;
    logic [CNT_W-1:0]     res_r_reg;
    logic [SUM_OUT_W-1:0] res_sum_reg;

    logic                 m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;

    logic             s_fire;
    logic             store_ok;
    box_t             in_box;
    logic             ram_we;
    logic             ram_re;
    logic [BOX_W-1:0] ram_rdata;
    box_t             rbox;

    logic signed [DIF_W-1:0] dax [3];
    logic [AXIS_W-1:0]       axis_next;
    logic [CEN_W-1:0]        c_rd;
    logic [DIF_W-1:0]        diff_next;
    logic [BK_W-1:0]         bk_next;

    logic [ST_W-1:0]  bidx_full;
    logic [BK_W-1:0]  bidx;
    box_t             base_box;
    box_t             grown_box;
    logic [N_W-1:0]   grown_cnt;
    logic [CUT_W-1:0] issue_tag;
    kind_t            issue_kind;
    logic             issue_en;

    logic signed [COORD_BITS:0] ext [3];
    logic [COORD_BITS-1:0]      ecl [3];
    logic [PROD_W-1:0]          wb_prod;
    logic [SUM_W-1:0]           cut_sum;
    logic [N_W+2:0]             mult_n;
    logic [COST_W-1:0]          rhs_next;
    logic [COST_W-1:0]          lhs_cost;
    logic                       do_split;
    logic                       bin_busy;
    logic                       area_busy;

    assign s_tready = (state_reg == S_LOAD);
    assign s_fire   = s_tvalid && s_tready;
    assign store_ok = (cnt_reg < N_W'(MAX_BOXES));
    assign in_box   = box_t'(s_tdata[BOX_W-1:0]);
    assign ram_we   = s_fire && store_ok;
    assign ram_re   = (state_reg == S_BIN) && (rd_cnt_reg < cnt_reg);
    assign rbox     = box_t'(ram_rdata);

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    sahbss_ram #(
        .WIDTH (BOX_W),
        .DEPTH (MAX_BOXES)
    ) u_box_ram (
        .clk     (aclk),
        .wr_en   (ram_we),
        .wr_addr (cnt_reg[ADDR_W-1:0]),
        .wr_data (BOX_W'(in_box)),
        .rd_en   (ram_re),
        .rd_addr (rd_cnt_reg[ADDR_W-1:0]),
        .rd_data (ram_rdata)
    );

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            dax[k] = $signed({ch_reg[k][CEN_W-1], ch_reg[k]})
                   - $signed({cl_reg[k][CEN_W-1], cl_reg[k]});
        end
        if (dax[0] > dax[1] && dax[0] > dax[2]) begin
            axis_next = AXIS_X;
        end else if (dax[1] > dax[2]) begin
            axis_next = AXIS_Y;
        end else begin
            axis_next = AXIS_Z;
        end
    end

    always_comb begin
        c_rd      = cen_sum(rbox.lo[axis_reg], rbox.hi[axis_reg]);
        diff_next = DIF_W'($signed({c_rd[CEN_W-1], c_rd})
                  - $signed({lowsel_reg[CEN_W-1], lowsel_reg}));
        bk_next   = '0;
        for (int k = 0; k < CUTS; k++) begin
            if (p2_sc_reg >= thr_reg[k]) bk_next = bk_next + BK_W'(1);
        end
    end

    always_comb begin
        issue_en   = (state_reg == S_CUT) && (st_reg <= ST_W'(2 * CUTS));
        bidx_full  = (st_reg < ST_W'(CUTS)) ? st_reg : ST_W'(2 * CUTS) - st_reg;
        bidx       = bidx_full[BK_W-1:0];
        base_box   = (st_reg == '0 || st_reg == ST_W'(CUTS)) ? empty_box() : acc_reg;
        grown_box  = box_grow(base_box, bbox_reg[bidx]);
        grown_cnt  = ((st_reg == '0 || st_reg == ST_W'(CUTS)) ? '0 : acnt_reg) + bcnt_reg[bidx];
        issue_tag  = '0;
        issue_kind = K_NODE;
        if (st_reg < ST_W'(CUTS)) begin
            issue_kind = K_LEFT;
            issue_tag  = CUT_W'(st_reg);
        end else if (st_reg < ST_W'(2 * CUTS)) begin
            issue_kind = K_RIGHT;
            issue_tag  = CUT_W'(bidx_full - ST_W'(1));
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            ext[k] = $signed({a_box_reg.hi[k][COORD_BITS-1], a_box_reg.hi[k]})
                   - $signed({a_box_reg.lo[k][COORD_BITS-1], a_box_reg.lo[k]});
            ecl[k] = ext[k][COORD_BITS] ? '0 : ext[k][COORD_BITS-1:0];
        end
        wb_prod   = PROD_W'(c_cnt_reg) * PROD_W'(c_area_reg);
        cut_sum   = SUM_W'(lsum_reg[bi_reg]) + SUM_W'(rsum_reg[bi_reg]);
        mult_n    = {cnt_reg, 3'b000} - (N_W+3)'(1);
        rhs_next  = COST_W'(mult_n) * COST_W'(narea_reg);
        lhs_cost  = COST_W'(best_reg) << 3;
        do_split  = (lhs_cost < rhs_reg) || (CMP_W'(cnt_reg) > CMP_W'(max_leaf_reg));
        bin_busy  = rv_reg || p1_valid_reg || p2_valid_reg || p3_valid_reg;
        area_busy = a_valid_reg || b_valid_reg || c_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_LOAD;
            cnt_reg      <= '0;
            nb_reg       <= empty_box();
            max_leaf_reg <= LEAF_RESET;
            for (int k = 0; k < 3; k++) begin
                cl_reg[k] <= CEN_MAX;
                ch_reg[k] <= CEN_MIN;
            end
            for (int b = 0; b < BUCKETS; b++) begin
                bcnt_reg[b] <= '0;
                bbox_reg[b] <= empty_box();
            end
            rd_cnt_reg   <= '0;
            rv_reg       <= 1'b0;
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
            a_valid_reg  <= 1'b0;
            b_valid_reg  <= 1'b0;
            c_valid_reg  <= 1'b0;
            st_reg       <= '0;
            bi_reg       <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wen) begin
                max_leaf_reg <= cfg_wdata;
            end
            if (state_reg == S_FIN && (!m_valid_reg || m_tready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end

            rv_reg       <= ram_re;
            p1_valid_reg <= rv_reg;
            p1_diff_reg  <= diff_next;
            p1_box_reg   <= rbox;
            p2_valid_reg <= p1_valid_reg;
            p2_sc_reg    <= SC_W'(p1_diff_reg) * SC_W'(BUCKETS);
            p2_box_reg   <= p1_box_reg;
            p3_valid_reg <= p2_valid_reg;
            p3_bk_reg    <= bk_next;
            p3_box_reg   <= p2_box_reg;
            if (p3_valid_reg) begin
                bcnt_reg[p3_bk_reg] <= bcnt_reg[p3_bk_reg] + N_W'(1);
                bbox_reg[p3_bk_reg] <= box_grow(bbox_reg[p3_bk_reg], p3_box_reg);
            end

            a_valid_reg <= issue_en;
            a_box_reg   <= (st_reg == ST_W'(2 * CUTS)) ? nb_reg : grown_box;
            a_cnt_reg   <= (st_reg == ST_W'(2 * CUTS)) ? N_W'(1) : grown_cnt;
            a_kind_reg  <= issue_kind;
            a_tag_reg   <= issue_tag;
            b_valid_reg <= a_valid_reg;
            b_p_reg[0]  <= (2*COORD_BITS)'(ecl[0]) * (2*COORD_BITS)'(ecl[1]);
            b_p_reg[1]  <= (2*COORD_BITS)'(ecl[1]) * (2*COORD_BITS)'(ecl[2]);
            b_p_reg[2]  <= (2*COORD_BITS)'(ecl[2]) * (2*COORD_BITS)'(ecl[0]);
            b_cnt_reg   <= a_cnt_reg;
            b_kind_reg  <= a_kind_reg;
            b_tag_reg   <= a_tag_reg;
            c_valid_reg <= b_valid_reg;
            c_area_reg  <= AREA_W'(b_p_reg[0]) + AREA_W'(b_p_reg[1]) + AREA_W'(b_p_reg[2]);
            c_cnt_reg   <= b_cnt_reg;
            c_kind_reg  <= b_kind_reg;
            c_tag_reg   <= b_tag_reg;
            if (c_valid_reg) begin
                unique case (c_kind_reg)
                    K_LEFT: begin
                        lsum_reg[c_tag_reg] <= wb_prod;
                        lcnt_reg[c_tag_reg] <= c_cnt_reg;
                    end
                    K_RIGHT: begin
                        rsum_reg[c_tag_reg] <= wb_prod;
                        rcnt_reg[c_tag_reg] <= c_cnt_reg;
                    end
                    default: begin
                        narea_reg <= c_area_reg;
                    end
                endcase
            end

            unique case (state_reg)
                S_LOAD: begin
                    if (s_fire) begin
                        if (store_ok) begin
                            cnt_reg <= cnt_reg + N_W'(1);
                            nb_reg  <= box_grow(nb_reg, in_box);
                            for (int k = 0; k < 3; k++) begin
                                if ($signed(cen_sum(in_box.lo[k], in_box.hi[k]))
                                        < $signed(cl_reg[k])) begin
                                    cl_reg[k] <= cen_sum(in_box.lo[k], in_box.hi[k]);
                                end
                                if ($signed(cen_sum(in_box.lo[k], in_box.hi[k]))
                                        > $signed(ch_reg[k])) begin
                                    ch_reg[k] <= cen_sum(in_box.lo[k], in_box.hi[k]);
                                end
                            end
                        end
                        if (s_tlast) begin
                            state_reg <= S_AXIS;
                        end
                    end
                end
                S_AXIS: begin
                    axis_reg        <= axis_next;
                    dsel_reg        <= DIF_W'(dax[axis_next]);
                    lowsel_reg      <= cl_reg[axis_next];
                    res_outcome_reg <= OUT_SINGLE;
                    res_axis_reg    <= '0;
                    res_bk_reg      <= '0;
                    res_l_reg       <= '0;
                    res_r_reg       <= '0;
                    res_sum_reg     <= '0;
                    if (cnt_reg == N_W'(1)) begin
                        state_reg <= S_FIN;
                    end else if (dax[axis_next] <= 0) begin
                        res_outcome_reg <= OUT_DEGEN;
                        res_axis_reg    <= axis_next;
                        state_reg       <= S_FIN;
                    end else begin
                        state_reg <= S_THR;
                    end
                end
                S_THR: begin
                    for (int k = 0; k < CUTS; k++) begin
                        thr_reg[k] <= SC_W'(k + 1) * SC_W'(dsel_reg);
                    end
                    rd_cnt_reg <= '0;
                    state_reg  <= S_BIN;
                end
                S_BIN: begin
                    if (ram_re) begin
                        rd_cnt_reg <= rd_cnt_reg + N_W'(1);
                    end else if (!bin_busy) begin
                        st_reg    <= '0;
                        state_reg <= S_CUT;
                    end
                end
                S_CUT: begin
                    if (issue_en) begin
                        acc_reg  <= grown_box;
                        acnt_reg <= grown_cnt;
                        st_reg   <= st_reg + ST_W'(1);
                    end else if (!area_busy) begin
                        bi_reg    <= '0;
                        state_reg <= S_BEST;
                    end
                end
                S_BEST: begin
                    if (bi_reg == '0 || cut_sum < best_reg) begin
                        best_reg <= cut_sum;
                        bcut_reg <= bi_reg;
                        bl_reg   <= lcnt_reg[bi_reg];
                        br_reg   <= rcnt_reg[bi_reg];
                    end
                    bi_reg <= bi_reg + CUT_W'(1);
                    if (bi_reg == CUT_W'(CUTS - 1)) begin
                        state_reg <= S_COST;
                    end
                end
                S_COST: begin
                    rhs_reg   <= rhs_next;
                    state_reg <= S_DEC;
                end
                S_DEC: begin
                    res_outcome_reg <= do_split ? OUT_SPLIT : OUT_COST_LEAF;
                    res_axis_reg    <= axis_reg;
                    res_bk_reg      <= BUCKET_W'(bcut_reg);
                    res_l_reg       <= CNT_W'(bl_reg);
                    res_r_reg       <= CNT_W'(br_reg);
                    res_sum_reg     <= SUM_OUT_W'(best_reg);
                    state_reg       <= S_FIN;
                end
                S_FIN: begin
                    if (!m_valid_reg || m_tready) begin
                        m_data_reg  <= M_TDATA_W'({res_sum_reg, res_r_reg, res_l_reg,
                                                   res_bk_reg, res_axis_reg, res_outcome_reg});
                        cnt_reg <= '0;
                        nb_reg  <= empty_box();
                        for (int k = 0; k < 3; k++) begin
                            cl_reg[k] <= CEN_MAX;
                            ch_reg[k] <= CEN_MIN;
                        end
                        for (int b = 0; b < BUCKETS; b++) begin
                            bcnt_reg[b] <= '0;
                            bbox_reg[b] <= empty_box();
                        end
                        state_reg <= S_LOAD;
                    end
                end
                default: begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= N_W'(MAX_BOXES))
        else $error("box count beyond the store depth");

    a_bucket_range: assert property (@(posedge aclk) disable iff (!aresetn)
        p3_valid_reg |-> ({1'b0, p3_bk_reg} < (BK_W+1)'(BUCKETS)))
        else $error("bucket index out of range");

    a_bin_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CUT) |-> !(rv_reg || p1_valid_reg || p2_valid_reg || p3_valid_reg))
        else $error("binning pipeline still busy during the cut sweep");

    a_box_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && store_ok) |=> (cnt_reg == $past(cnt_reg) + N_W'(1)) || (state_reg == S_AXIS))
        else $error("box count did not advance on a stored box");

endmodule
`default_nettype wire

// ----- dv/sah_binned_split_select_test.sv -----
`timescale 1ns / 100ps
module sah_binned_split_select_test;
    import sahbss_pkg::*;

    localparam longint BIG = 64'sd1 << 40;
    localparam int NB = 12;
    localparam int STORE = 256;
    localparam int SETTLE = 400;
    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        logic [SUM_OUT_W-1:0] sum;
        logic [CNT_W-1:0]     right;
        logic [CNT_W-1:0]     left;
        logic [BUCKET_W-1:0]  bucket;
        logic [AXIS_W-1:0]    axis;
        outcome_t             outcome;
    } decision_t;

    typedef struct {
        logic [95:0] box;
        bit          last;
        bit          typed;
        decision_t   want;
    } row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [95:0]          s_tdata = '0;
    logic                 s_tlast = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_wen = 1'b0;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    sah_binned_split_select dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata)
    );

    always #5 aclk = ~aclk;

    decision_t pending_decisions[$];
    row_t rows[$];
    int errors = 0;
    int tx_idle = 0;
    int rx_idle = 0;
    int quiet_cycles = 0;

    // Shadow of the node under construction.
    longint store_lo[STORE][3];
    longint store_hi[STORE][3];
    int box_total;
    longint nb_lo[3], nb_hi[3], cen_lo[3], cen_hi[3];
    logic [CFG_W-1:0] leaf_limit;

    function automatic longint unsigned extent(longint hi, longint lo);
        return (hi > lo) ? longint'(hi - lo) : 0;
    endfunction

    function automatic longint unsigned half_area(longint lo[3], longint hi[3]);
        longint unsigned ex, ey, ez;
        ex = extent(hi[0], lo[0]);
        ey = extent(hi[1], lo[1]);
        ez = extent(hi[2], lo[2]);
        return ex * ey + ey * ez + ez * ex;
    endfunction

    function automatic void clear_node();
        box_total = 0;
        for (int k = 0; k < 3; k++) begin
            nb_lo[k] = BIG; nb_hi[k] = -BIG; cen_lo[k] = BIG; cen_hi[k] = -BIG;
        end
    endfunction

    function automatic void add_row(logic [95:0] box, bit last, bit typed, decision_t want);
        row_t r;
        r.box = box;
        r.last = last;
        r.typed = typed;
        r.want = want;
        rows.insert(rows.size(), r);
    endfunction

    function automatic decision_t choose_split();
        decision_t r;
        longint d[3];
        int axis;
        int bk_cnt[NB];
        longint bk_lo[NB][3], bk_hi[NB][3];
        longint l_lo[3], l_hi[3], r_lo[3], r_hi[3];
        longint b;
        longint unsigned s, best, area;
        int cl, cr;
        r = '0;
        if (box_total == 1) begin
            r.outcome = OUT_SINGLE;
            return r;
        end
        for (int k = 0; k < 3; k++) d[k] = cen_hi[k] - cen_lo[k];
        if (d[0] > d[1] && d[0] > d[2]) axis = 0;
        else if (d[1] > d[2]) axis = 1;
        else axis = 2;
        r.axis = AXIS_W'(axis);
        if (d[axis] <= 0) begin
            r.outcome = OUT_DEGEN;
            return r;
        end
        for (int j = 0; j < NB; j++) begin
            bk_cnt[j] = 0;
            for (int k = 0; k < 3; k++) begin bk_lo[j][k] = BIG; bk_hi[j][k] = -BIG; end
        end
        for (int i = 0; i < box_total; i++) begin
            b = (NB * (store_lo[i][axis] + store_hi[i][axis] - cen_lo[axis])) / d[axis];
            if (b > NB - 1) b = NB - 1;
            bk_cnt[b]++;
            for (int k = 0; k < 3; k++) begin
                if (store_lo[i][k] < bk_lo[b][k]) bk_lo[b][k] = store_lo[i][k];
                if (store_hi[i][k] > bk_hi[b][k]) bk_hi[b][k] = store_hi[i][k];
            end
        end
        best = 0;
        for (int i = 0; i < NB - 1; i++) begin
            cl = 0; cr = 0;
            for (int k = 0; k < 3; k++) begin
                l_lo[k] = BIG; l_hi[k] = -BIG; r_lo[k] = BIG; r_hi[k] = -BIG;
            end
            for (int j = 0; j < NB; j++) begin
                for (int k = 0; k < 3; k++) begin
                    if (j <= i) begin
                        if (bk_lo[j][k] < l_lo[k]) l_lo[k] = bk_lo[j][k];
                        if (bk_hi[j][k] > l_hi[k]) l_hi[k] = bk_hi[j][k];
                    end else begin
                        if (bk_lo[j][k] < r_lo[k]) r_lo[k] = bk_lo[j][k];
                        if (bk_hi[j][k] > r_hi[k]) r_hi[k] = bk_hi[j][k];
                    end
                end
                if (j <= i) cl += bk_cnt[j];
                else cr += bk_cnt[j];
            end
            s = longint'(cl) * half_area(l_lo, l_hi) + longint'(cr) * half_area(r_lo, r_hi);
            if (i == 0 || s < best) begin
                best = s;
                r.bucket = BUCKET_W'(i);
                r.left = CNT_W'(cl);
                r.right = CNT_W'(cr);
            end
        end
        area = half_area(nb_lo, nb_hi);
        if (8 * best < (8 * longint'(box_total) - 1) * area || box_total > leaf_limit)
            r.outcome = OUT_SPLIT;
        else
            r.outcome = OUT_COST_LEAF;
        r.sum = best[SUM_OUT_W-1:0];
        return r;
    endfunction

    // Returns 1 when the box closes the node; the decision is then in want.
    function automatic bit absorb_box(logic [95:0] box, bit last, output decision_t want);
        longint lo, hi;
        want = '0;
        if (box_total < STORE) begin
            for (int k = 0; k < 3; k++) begin
                lo = longint'($signed(box[16*k +: 16]));
                hi = longint'($signed(box[16*(k+3) +: 16]));
                store_lo[box_total][k] = lo;
                store_hi[box_total][k] = hi;
                if (lo + hi < cen_lo[k]) cen_lo[k] = lo + hi;
                if (lo + hi > cen_hi[k]) cen_hi[k] = lo + hi;
                if (lo < nb_lo[k]) nb_lo[k] = lo;
                if (hi > nb_hi[k]) nb_hi[k] = hi;
            end
            box_total++;
        end
        if (!last) return 0;
        want = choose_split();
        clear_node();
        return 1;
    endfunction

    task automatic send_box(logic [95:0] box, bit last, bit typed, decision_t typed_want);
        decision_t want;
        if ($urandom_range(99) < tx_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < tx_idle) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= box;
        s_tlast <= last;
        do @(posedge aclk); while (!s_tready);
        if (absorb_box(box, last, want))
            pending_decisions.insert(pending_decisions.size(), typed ? typed_want : want);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_decisions.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_leaf_limit(logic [CFG_W-1:0] value);
        cfg_wen <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wen <= 1'b0;
        leaf_limit = value;
    endtask

    function automatic logic [15:0] coord(int centre, int spread);
        int v;
        v = centre + $signed($urandom_range(2 * spread)) - spread;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    function automatic logic [95:0] random_box();
        logic [95:0] box;
        int c, h;
        if ($urandom_range(9) == 0) return {$urandom, $urandom, $urandom};
        for (int k = 0; k < 3; k++) begin
            c = $signed($urandom_range(60000)) - 30000;
            h = $urandom_range(($urandom_range(3) == 0) ? 2000 : 40);
            box[16*k +: 16] = coord(c - h, 0);
            box[16*(k+3) +: 16] = coord(c + h, 0);
            if ($urandom_range(19) == 0) box[16*k +: 16] = coord(c + h + 5, 0);
        end
        return box;
    endfunction

    function automatic logic [95:0] mk(int x0, int y0, int z0, int x1, int y1, int z1);
        return {16'(z1), 16'(y1), 16'(x1), 16'(z0), 16'(y0), 16'(x0)};
    endfunction

    task automatic random_nodes(int item_budget);
        int sent, n, pick;
        logic [95:0] same;
        sent = 0;
        while (sent < item_budget) begin
            pick = $urandom_range(99);
            if (pick < 12) n = 1;
            else if (pick < 80) n = $urandom_range(12, 2);
            else if (pick < 97) n = $urandom_range(40, 13);
            else n = $urandom_range(270, 250);
            same = random_box();
            for (int i = 0; i < n; i++)
                send_box(($urandom_range(19) == 0) ? same : random_box(), i == n - 1, 0, '0);
            sent += n;
        end
    endtask

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= rx_idle);
    end

    always @(posedge aclk) begin
        decision_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_decisions.size() == 0) begin
                $error("decision with none expected: %h", m_tdata);
                errors++;
            end else begin
                want = pending_decisions.pop_front();
                if (m_tdata[1:0] !== want.outcome) begin
                    $error("outcome: expected %0d, got %0d", want.outcome, m_tdata[1:0]);
                    errors++;
                end
                if (m_tdata[3:2] !== want.axis) begin
                    $error("split_axis: expected %0d, got %0d", want.axis, m_tdata[3:2]);
                    errors++;
                end
                if (m_tdata[7:4] !== want.bucket) begin
                    $error("split_bucket: expected %0d, got %0d", want.bucket, m_tdata[7:4]);
                    errors++;
                end
                if (m_tdata[16:8] !== want.left) begin
                    $error("left_count: expected %0d, got %0d", want.left, m_tdata[16:8]);
                    errors++;
                end
                if (m_tdata[25:17] !== want.right) begin
                    $error("right_count: expected %0d, got %0d", want.right, m_tdata[25:17]);
                    errors++;
                end
                if (m_tdata[67:26] !== want.sum) begin
                    $error("best_area_sum: expected %0d, got %0d", want.sum, m_tdata[67:26]);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("** sah_binned_split_select: FAILED **");
            $finish;
        end
    end

    initial begin
        decision_t single_leaf, flat_z;
        single_leaf = '0;
        single_leaf.outcome = OUT_SINGLE;
        flat_z = '0;
        flat_z.outcome = OUT_DEGEN;
        flat_z.axis = AXIS_Z;

        add_row(mk(-32768, -32768, -32768, 32767, 32767, 32767), 1, 1, single_leaf);
        add_row(mk(32767, 32767, 32767, -32768, -32768, -32768), 1, 1, single_leaf);
        add_row(mk(0, 0, 0, 5, 5, 5), 0, 0, '0);
        add_row(mk(0, 0, 0, 5, 5, 5), 1, 1, flat_z);
        add_row(mk(0, 0, 0, 1, 1, 1), 0, 0, '0);
        add_row(mk(10, 0, 0, 11, 1, 1), 1, 0, '0);
        add_row(mk(-32768, -32768, -32768, -32768, -32768, -32768), 0, 0, '0);
        add_row(mk(0, 0, 0, 0, 0, 0), 0, 0, '0);
        add_row(mk(32767, 32767, 32767, 32767, 32767, 32767), 1, 0, '0);
        add_row(mk(-100, 0, 0, -90, 0, 0), 0, 0, '0);
        add_row(mk(100, 0, 0, 110, 0, 0), 1, 0, '0);
        add_row(mk(10, 0, 0, 0, 5, 5), 0, 0, '0);
        add_row(mk(20, 0, 0, 15, 5, 5), 1, 0, '0);
        add_row(mk(0, 0, 0, 2, 2, 2), 0, 0, '0);
        add_row(mk(4, 4, 4, 6, 6, 6), 1, 0, '0);
        add_row(mk(0, 0, 0, 1, 3, 3), 0, 0, '0);
        add_row(mk(0, 8, 8, 1, 9, 9), 1, 0, '0);

        leaf_limit = LEAF_RESET;
        clear_node();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        tx_idle = 30;
        rx_idle = 70;
        foreach (rows[i]) send_box(rows[i].box, rows[i].last, rows[i].typed, rows[i].want);
        wait_idle();
        random_nodes(300);

        wait_idle();
        write_leaf_limit(9'd1);
        tx_idle = 70;
        rx_idle = 30;
        random_nodes(300);

        wait_idle();
        write_leaf_limit(9'd256);
        tx_idle = 0;
        rx_idle = 0;
        random_nodes(300);

        wait_idle();
        write_leaf_limit(9'($urandom_range(20, 2)));
        random_nodes(300);

        wait_idle();
        if (errors == 0)
            $display("** sah_binned_split_select: PASSED **");
        else
            $display("** sah_binned_split_select: FAILED **");
        $finish;
    end
endmodule

// ----- files.f -----
design/sahbss_pkg.sv
design/sahbss_ram.sv
design/sah_binned_split_select.sv
dv/sah_binned_split_select_test.sv
